// ===== hdl/mch_pkg.sv =====
// ----------------------------------------------------------------------------
// mch_pkg: shared types and constants of the MIDI chord hold unit
// Message words, result words, register indexes and the control groups that
// pass between the sequencer, the note map and the register file.
// ----------------------------------------------------------------------------
package mch_pkg;

   localparam logic [3:0] TYPE_NOTE_OFF    = 4'h8;
   localparam logic [3:0] TYPE_NOTE_ON     = 4'h9;
   localparam logic [3:0] TYPE_CONTROL     = 4'hB;
   localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;

   localparam logic KIND_FORWARD = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic REG_POWER_ON     = 1'b0;
   localparam logic REG_HOLD_CHANNEL = 1'b1;

   localparam int MAP_WORDS     = 32;
   localparam int MAP_ADDR_W    = 5;
   localparam int MAP_DATA_W    = 64;
   localparam int APB_ADDR_W    = 3;
   localparam int APB_DATA_W    = 32;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [7:0] data_one;
      logic [7:0] data_two;
   } req_word_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  out_status;
      logic [7:0]  out_data_one;
      logic [7:0]  out_data_two;
      logic [3:0]  release_channel;
      logic        release_half;
      logic [63:0] release_mask;
      logic        last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic       power_on;
      logic [3:0] hold_channel;
   } cfg_type;

   typedef struct packed {
      logic                  rd_en;
      logic [MAP_ADDR_W-1:0] rd_addr;
      logic                  wr_en;
      logic [MAP_ADDR_W-1:0] wr_addr;
      logic                  clr_en;
      logic [MAP_ADDR_W-1:0] clr_addr;
   } map_ctrl_type;

endpackage

// ===== hdl/mch_csr.sv =====
// ----------------------------------------------------------------------------
// mch_csr: configuration registers
// Holds the power and held-channel settings behind a simple APB-style port.
// ----------------------------------------------------------------------------
module mch_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mch_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [mch_pkg::APB_DATA_W-1:0] pwdata,
   output logic [mch_pkg::APB_DATA_W-1:0] prdata,
   output logic                          pready,
   output mch_pkg::cfg_type              cfg
);
   import mch_pkg::*;

   logic       power_on_ff;
   logic       power_on_in;
   logic [3:0] hold_channel_ff;
   logic [3:0] hold_channel_in;
   logic       wr_strobe;
   logic       reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[2];
   assign wr_strobe = psel && penable && pwrite;

   always_comb begin
      power_on_in     = power_on_ff;
      hold_channel_in = hold_channel_ff;
      if (wr_strobe) begin
         case (reg_index)
            REG_POWER_ON:     power_on_in     = pwdata[0];
            REG_HOLD_CHANNEL: hold_channel_in = pwdata[3:0];
            default:          power_on_in     = power_on_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_POWER_ON:     prdata = {{(APB_DATA_W-1){1'b0}}, power_on_ff};
         REG_HOLD_CHANNEL: prdata = {{(APB_DATA_W-4){1'b0}}, hold_channel_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_on_ff     <= 1'b1;
         hold_channel_ff <= 4'd0;
      end else begin
         power_on_ff     <= power_on_in;
         hold_channel_ff <= hold_channel_in;
      end
   end

   assign cfg.power_on     = power_on_ff;
   assign cfg.hold_channel = hold_channel_ff;

endmodule

// ===== hdl/mch_note_ram.sv =====
// ----------------------------------------------------------------------------
// mch_note_ram: map of sounding notes
// Thirty-two 64-bit words, one per channel half, with a live bit per word
// that is set exactly when the word holds a sounding note.
// ----------------------------------------------------------------------------
module mch_note_ram (
   input  logic                             clock,
   input  logic                             reset,
   input  mch_pkg::map_ctrl_type            ctrl,
   input  logic [mch_pkg::MAP_DATA_W-1:0]   wr_data,
   output logic [mch_pkg::MAP_DATA_W-1:0]   rd_data,
   output logic [mch_pkg::MAP_WORDS-1:0]    live
);
   import mch_pkg::*;

   logic [MAP_DATA_W-1:0] note_mem_ff [MAP_WORDS];
   logic [MAP_DATA_W-1:0] rd_mem_ff;
   logic                  rd_live_ff;
   logic [MAP_WORDS-1:0]  live_ff;
   logic [MAP_WORDS-1:0]  live_in;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         note_mem_ff[ctrl.wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_mem_ff <= note_mem_ff[ctrl.rd_addr];
      end
   end

   always_comb begin
      live_in = live_ff;
      if (ctrl.wr_en) begin
         live_in[ctrl.wr_addr] = (wr_data != '0);
      end
      if (ctrl.clr_en) begin
         live_in[ctrl.clr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff    <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
         if (ctrl.rd_en) begin
            rd_live_ff <= live_ff[ctrl.rd_addr];
         end
      end
   end

   assign rd_data = rd_live_ff ? rd_mem_ff : '0;
   assign live    = live_ff;

endmodule

// ===== hdl/mch_ctrl.sv =====
// ----------------------------------------------------------------------------
// mch_ctrl: message sequencer
// Decodes one message, sweeps the note map for releases, updates one map word
// through a read-modify-write and drives the registered result word.
// ----------------------------------------------------------------------------
module mch_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mch_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mch_pkg::rsp_word_type          rsp_word,
   input  mch_pkg::cfg_type               cfg,
   output mch_pkg::map_ctrl_type          map_ctrl,
   output logic [mch_pkg::MAP_DATA_W-1:0] map_wr_data,
   input  logic [mch_pkg::MAP_DATA_W-1:0] map_rd_data,
   input  logic [mch_pkg::MAP_WORDS-1:0]  map_live
);
   import mch_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SWEEP = 3'd1;
   localparam logic [2:0] ST_EMIT  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam logic [2:0] ST_FWD   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic                  holding_ff, holding_in;
   logic                  power_was_ff, power_was_in;
   logic [3:0]            prev_chan_ff, prev_chan_in;
   req_word_type          msg_ff, msg_in;
   logic [MAP_ADDR_W-1:0] cnt_ff, cnt_in;
   logic [MAP_ADDR_W-1:0] end_ff, end_in;
   logic                  discard_ff, discard_in;
   logic                  update_ff, update_in;
   logic                  set_ff, set_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic [3:0]            msg_type;
   logic [3:0]            msg_chan;
   logic [6:0]            msg_d1;
   logic [6:0]            msg_d2;
   logic                  accept;
   logic                  chg_release;
   logic                  hold_now;
   logic                  is_on;
   logic                  is_off;
   logic                  held_chan;
   logic                  all_off;
   logic                  rel_chan;
   logic                  discard_now;
   logic                  update_now;
   logic                  out_free;
   logic [MAP_ADDR_W-1:0] upd_addr;
   logic [MAP_DATA_W-1:0] bit_mask;
   logic [MAP_WORDS-1:0]  above_mask;
   logic [MAP_WORDS-1:0]  range_mask;
   logic                  more_live;
   logic [2:0]            after_sweep;

   assign msg_type = req_word.status_byte[7:4];
   assign msg_chan = req_word.status_byte[3:0];
   assign msg_d1   = req_word.data_one[6:0];
   assign msg_d2   = req_word.data_two[6:0];

   assign accept      = (state_ff == ST_IDLE) && req_valid;
   assign chg_release = ((!cfg.power_on && power_was_ff) || (cfg.hold_channel != prev_chan_ff))
                        && holding_ff;
   assign hold_now    = holding_ff && !chg_release;
   assign is_on       = (msg_type == TYPE_NOTE_ON) && (msg_d2 != 7'd0);
   assign is_off      = (msg_type == TYPE_NOTE_OFF)
                        || ((msg_type == TYPE_NOTE_ON) && (msg_d2 == 7'd0));
   assign held_chan   = cfg.power_on && (msg_chan == cfg.hold_channel);
   assign all_off     = (msg_type == TYPE_CONTROL) && (msg_d1 == CC_ALL_NOTES_OFF);
   assign rel_chan    = is_on && held_chan && hold_now;
   assign discard_now = is_off && held_chan;
   assign update_now  = is_on || (is_off && !held_chan);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign upd_addr = {msg_ff.status_byte[3:0], msg_ff.data_one[6]};
   assign bit_mask = {{(MAP_DATA_W-1){1'b0}}, 1'b1} << msg_ff.data_one[5:0];

   assign above_mask = ~((32'd2 << cnt_ff) - 32'd1);
   assign range_mask = (32'd2 << end_ff) - 32'd1;
   assign more_live  = |(map_live & above_mask & range_mask);

   assign after_sweep = update_ff ? ST_READ : (discard_ff ? ST_IDLE : ST_FWD);

   always_comb begin
      state_in     = state_ff;
      holding_in   = holding_ff;
      power_was_in = power_was_ff;
      prev_chan_in = prev_chan_ff;
      msg_in       = msg_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      discard_in   = discard_ff;
      update_in    = update_ff;
      set_in       = set_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      map_ctrl     = '0;
      map_wr_data  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               msg_in       = req_word;
               discard_in   = discard_now;
               update_in    = update_now;
               set_in       = is_on;
               prev_chan_in = cfg.hold_channel;
               power_was_in = cfg.power_on;
               if (all_off || rel_chan) begin
                  holding_in = 1'b0;
               end else if (discard_now) begin
                  holding_in = 1'b1;
               end else begin
                  holding_in = hold_now;
               end
               if (chg_release || all_off) begin
                  cnt_in   = '0;
                  end_in   = '1;
                  state_in = ST_SWEEP;
               end else if (rel_chan) begin
                  cnt_in   = {msg_chan, 1'b0};
                  end_in   = {msg_chan, 1'b1};
                  state_in = ST_SWEEP;
               end else if (update_now) begin
                  state_in = ST_READ;
               end else if (discard_now) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FWD;
               end
            end
         end
         ST_SWEEP: begin
            if (map_live[cnt_ff]) begin
               map_ctrl.rd_en   = 1'b1;
               map_ctrl.rd_addr = cnt_ff;
               state_in         = ST_EMIT;
            end else if (cnt_ff == end_ff) begin
               state_in = after_sweep;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in                 = '0;
               rsp_word_in.item_kind       = KIND_RELEASE;
               rsp_word_in.release_channel = cnt_ff[MAP_ADDR_W-1:1];
               rsp_word_in.release_half    = cnt_ff[0];
               rsp_word_in.release_mask    = map_rd_data;
               rsp_word_in.last_of_run     = discard_ff && !more_live;
               map_ctrl.clr_en             = 1'b1;
               map_ctrl.clr_addr           = cnt_ff;
               if (cnt_ff == end_ff) begin
                  state_in = after_sweep;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_READ: begin
            map_ctrl.rd_en   = 1'b1;
            map_ctrl.rd_addr = upd_addr;
            state_in         = ST_WRITE;
         end
         ST_WRITE: begin
            map_ctrl.wr_en   = 1'b1;
            map_ctrl.wr_addr = upd_addr;
            map_wr_data      = set_ff ? (map_rd_data | bit_mask) : (map_rd_data & ~bit_mask);
            state_in         = ST_FWD;
         end
         ST_FWD: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in              = '0;
               rsp_word_in.item_kind    = KIND_FORWARD;
               rsp_word_in.out_status   = msg_ff.status_byte;
               rsp_word_in.out_data_one = msg_ff.data_one;
               rsp_word_in.out_data_two = msg_ff.data_two;
               rsp_word_in.last_of_run  = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         holding_ff   <= 1'b0;
         power_was_ff <= 1'b0;
         prev_chan_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         holding_ff   <= holding_in;
         power_was_ff <= power_was_in;
         prev_chan_ff <= prev_chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff      <= msg_in;
      cnt_ff      <= cnt_in;
      end_ff      <= end_in;
      discard_ff  <= discard_in;
      update_ff   <= update_in;
      set_ff      <= set_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== hdl/midi_chord_hold_unit.sv =====
// ----------------------------------------------------------------------------
// midi_chord_hold_unit: MIDI chord hold filter
// Latches chords on one channel and releases them as 64-note masks per
// channel half, forwarding all other messages unchanged.
// ----------------------------------------------------------------------------
// Channel   Ports                          Word
// request   req_valid, req_stall, req_word one MIDI message
// response  rsp_valid, rsp_stall, rsp_word forwarded message or release mask
// config    psel, penable, pwrite, paddr   power_on at 0, hold_channel at 4
//
// A message is taken while the sequencer is idle, then a release scan visits each map
// word in its range (32 for a full release, 2 for one channel) and emits one mask per word
// that holds notes; a note update adds a read and a write of the map, and the
// forwarded word, if the message is not swallowed, comes last.
// Reset clears the map at once through its per-word live bits.
// A stalled response holds the sequencer until the output register drains.
// ----------------------------------------------------------------------------
module midi_chord_hold_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mch_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mch_pkg::rsp_word_type          rsp_word,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mch_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [mch_pkg::APB_DATA_W-1:0] pwdata,
   output logic [mch_pkg::APB_DATA_W-1:0] prdata,
   output logic                           pready
);
   import mch_pkg::*;

   cfg_type               cfg;
   map_ctrl_type          map_ctrl;
   logic [MAP_DATA_W-1:0] map_wr_data;
   logic [MAP_DATA_W-1:0] map_rd_data;
   logic [MAP_WORDS-1:0]  map_live;

   mch_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mch_note_ram u_note_ram (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (map_ctrl),
      .wr_data (map_wr_data),
      .rd_data (map_rd_data),
      .live    (map_live)
   );

   mch_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .cfg         (cfg),
      .map_ctrl    (map_ctrl),
      .map_wr_data (map_wr_data),
      .map_rd_data (map_rd_data),
      .map_live    (map_live)
   );

endmodule

// ===== verif/midi_chord_hold_unit_tb.sv =====
// ----------------------------------------------------------------------------
// midi_chord_hold_unit_tb: self-checking testbench of the MIDI chord hold unit
// Sends MIDI message words, keeps its own copy of the note map and hold flags
// to predict forwarded words and release masks, and checks every response
// word in order. Directed messages and register changes come first, then
// random chord traffic under several settings with random idling on both
// sides in all phases but one.
// ----------------------------------------------------------------------------
module midi_chord_hold_unit_tb;
   import mch_pkg::*;

   localparam int IDLE_PERCENT    = 32;
   localparam int SETTLE_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int RANDOM_MESSAGES = 304;
   localparam int RANDOM_PHASES   = 8;
   localparam int PRINT_LIMIT     = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [APB_ADDR_W-1:0] paddr = '0;
   logic [APB_DATA_W-1:0] pwdata = '0;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   bit                    gaps_on = 1'b1;
   bit                    stall_on = 1'b1;
   int                    quiet_cycles = 0;
   int                    mismatch_count = 0;
   int                    messages_sent = 0;
   int                    words_checked = 0;
   int                    masks_checked = 0;
   int                    settings_written = 0;

   logic [63:0]           sounding_notes [MAP_WORDS];
   bit                    chord_latched = 1'b0;
   bit                    awaiting_note_off = 1'b1;
   bit                    power_seen_on = 1'b0;
   logic [3:0]            last_hold_channel = 4'd0;
   bit                    power_on_setting = 1'b1;
   logic [3:0]            hold_channel_setting = 4'd0;
   rsp_word_type          step_words [$];
   rsp_word_type          expected_words [$];

   midi_chord_hold_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      foreach (sounding_notes[i]) sounding_notes[i] = '0;
   end

   // Note map and hold flags as the block should keep them.
   function automatic void release_notes_of(input logic [3:0] channel);
      rsp_word_type w;
      for (int half = 0; half < 2; half++) begin
         if (sounding_notes[{channel, half[0]}] != 64'd0) begin
            w = '0;
            w.item_kind = KIND_RELEASE;
            w.release_channel = channel;
            w.release_half = half[0];
            w.release_mask = sounding_notes[{channel, half[0]}];
            sounding_notes[{channel, half[0]}] = 64'd0;
            step_words.insert(step_words.size(), w);
         end
      end
   endfunction

   function automatic void release_every_note();
      for (int channel = 0; channel < 16; channel++) release_notes_of(4'(channel));
   endfunction

   function automatic void predict_message(input req_word_type m);
      logic [3:0]   kind;
      logic [3:0]   channel;
      logic [6:0]   note;
      bit           swallowed;
      rsp_word_type w;
      kind = m.status_byte[7:4];
      channel = m.status_byte[3:0];
      note = m.data_one[6:0];
      swallowed = 1'b0;
      step_words.delete();
      if ((!power_on_setting && power_seen_on) || hold_channel_setting != last_hold_channel) begin
         if (chord_latched) begin
            release_every_note();
            chord_latched = 1'b0;
            awaiting_note_off = 1'b1;
         end
      end
      last_hold_channel = hold_channel_setting;
      if (kind == TYPE_NOTE_ON && m.data_two[6:0] == 7'd0) kind = TYPE_NOTE_OFF;
      if (kind == TYPE_NOTE_ON) begin
         if (power_on_setting && channel == hold_channel_setting && chord_latched) begin
            release_notes_of(channel);
            chord_latched = 1'b0;
            awaiting_note_off = 1'b1;
         end
         sounding_notes[{channel, note[6]}][note[5:0]] = 1'b1;
      end else if (kind == TYPE_NOTE_OFF) begin
         if (power_on_setting && channel == hold_channel_setting && chord_latched) begin
            swallowed = 1'b1;
         end else if (power_on_setting && channel == hold_channel_setting && awaiting_note_off) begin
            chord_latched = 1'b1;
            awaiting_note_off = 1'b0;
            swallowed = 1'b1;
         end else begin
            sounding_notes[{channel, note[6]}][note[5:0]] = 1'b0;
         end
      end else if (kind == TYPE_CONTROL && m.data_one[6:0] == CC_ALL_NOTES_OFF) begin
         release_every_note();
         chord_latched = 1'b0;
         awaiting_note_off = 1'b1;
      end
      if (!swallowed) begin
         w = '0;
         w.item_kind = KIND_FORWARD;
         w.out_status = m.status_byte;
         w.out_data_one = m.data_one;
         w.out_data_two = m.data_two;
         step_words.insert(step_words.size(), w);
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].last_of_run = 1'b1;
      foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
      power_seen_on = power_on_setting;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] word %0d: %s got %h, expected %h", $time, words_checked, what,
                  got, want);
      mismatch_count++;
   endtask

   task automatic compare_field(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic check_result_word(input rsp_word_type got);
      rsp_word_type want;
      if (expected_words.size() == 0) begin
         report_mismatch("unexpected word (status or mask)",
                         got.item_kind ? got.release_mask : 64'(got.out_status), 64'd0);
      end else begin
         want = expected_words.pop_front();
         compare_field("item_kind", 64'(got.item_kind), 64'(want.item_kind));
         compare_field("out_status", 64'(got.out_status), 64'(want.out_status));
         compare_field("out_data_one", 64'(got.out_data_one), 64'(want.out_data_one));
         compare_field("out_data_two", 64'(got.out_data_two), 64'(want.out_data_two));
         compare_field("release_channel", 64'(got.release_channel),
                       64'(want.release_channel));
         compare_field("release_half", 64'(got.release_half), 64'(want.release_half));
         compare_field("release_mask", got.release_mask, want.release_mask);
         compare_field("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
         if (want.item_kind == KIND_RELEASE) masks_checked++;
      end
      words_checked++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= stall_on && ($urandom_range(99) < IDLE_PERCENT);
      if (!reset && rsp_valid && !rsp_stall) check_result_word(rsp_word);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("[%0t] no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("midi_chord_hold_unit: mismatch");
         $finish;
      end
   end

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic req_word_type make_word(input logic [3:0] kind, input logic [3:0] channel,
                                              input logic [7:0] first, input logic [7:0] second);
      req_word_type w;
      w.status_byte = {kind, channel};
      w.data_one = first;
      w.data_two = second;
      return w;
   endfunction

   function automatic req_word_type note_on_word(input logic [3:0] channel);
      return make_word(TYPE_NOTE_ON, channel, random_byte(),
                       {1'($urandom_range(1)), 7'($urandom_range(127, 1))});
   endfunction

   function automatic req_word_type note_off_word(input logic [3:0] channel);
      if ($urandom_range(1) == 0)
         return make_word(TYPE_NOTE_OFF, channel, random_byte(), random_byte());
      return make_word(TYPE_NOTE_ON, channel, random_byte(), {1'($urandom_range(1)), 7'd0});
   endfunction

   task automatic send_message(input req_word_type m);
      while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= m;
      do @(posedge clock); while (req_stall);
      predict_message(m);
      messages_sent++;
   endtask

   task automatic wait_until_drained(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [APB_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (index == REG_POWER_ON) power_on_setting = value[0];
      else hold_channel_setting = value[3:0];
      settings_written++;
   endtask

   task automatic test_directed_messages;
      send_message(make_word(TYPE_NOTE_ON, 4'd0, 8'h3C, 8'h64));
      send_message(make_word(TYPE_NOTE_ON, 4'd0, 8'h40, 8'h7F));
      send_message(make_word(TYPE_NOTE_ON, 4'd0, 8'h00, 8'h01));
      send_message(make_word(TYPE_NOTE_ON, 4'd0, 8'hFF, 8'hFF));
      // The first note-off latches the chord, later ones are swallowed.
      send_message(make_word(TYPE_NOTE_OFF, 4'd0, 8'h3C, 8'h00));
      send_message(make_word(TYPE_NOTE_ON, 4'd0, 8'h40, 8'h00));
      send_message(make_word(TYPE_NOTE_OFF, 4'd0, 8'h7F, 8'h40));
      send_message(make_word(TYPE_NOTE_ON, 4'd1, 8'h24, 8'h50));
      send_message(make_word(TYPE_NOTE_ON, 4'd0, 8'h30, 8'h50));
      send_message(make_word(TYPE_NOTE_OFF, 4'd1, 8'h24, 8'h00));
      // A velocity byte with only its top bit set counts as zero.
      send_message(make_word(TYPE_NOTE_ON, 4'd0, 8'h30, 8'h80));
      send_message(make_word(TYPE_NOTE_ON, 4'd15, 8'h7F, 8'h7F));
      send_message(make_word(TYPE_CONTROL, 4'd0, 8'hFB, 8'h00));
      send_message(make_word(TYPE_CONTROL, 4'd3, 8'h7B, 8'h00));
      send_message(make_word(4'hA, 4'd0, 8'h3C, 8'h20));
      send_message(make_word(4'hC, 4'd5, 8'h05, 8'h00));
      send_message(make_word(4'hE, 4'd2, 8'h00, 8'h40));
      send_message(make_word(4'hF, 4'd8, 8'h00, 8'h00));
      send_message(make_word(4'h4, 4'd5, 8'h12, 8'h34));
      send_message(make_word(4'h0, 4'd0, 8'h00, 8'h00));
      send_message(make_word(4'hF, 4'd15, 8'hFF, 8'hFF));
      send_message(make_word(TYPE_CONTROL, 4'd15, 8'h7A, 8'h7F));
   endtask

   task automatic test_register_changes;
      wait_until_drained(SETTLE_CYCLES);
      write_register(REG_HOLD_CHANNEL, 32'd15);
      send_message(make_word(TYPE_NOTE_ON, 4'd15, 8'h10, 8'h40));
      send_message(make_word(TYPE_NOTE_ON, 4'd15, 8'h70, 8'h40));
      send_message(make_word(TYPE_NOTE_OFF, 4'd15, 8'h10, 8'h00));
      // Switching power off releases the latched chord on the next word.
      wait_until_drained(SETTLE_CYCLES);
      write_register(REG_POWER_ON, 32'd0);
      send_message(make_word(4'hF, 4'd8, 8'h00, 8'h00));
      send_message(make_word(TYPE_NOTE_OFF, 4'd15, 8'h10, 8'h00));
      send_message(make_word(TYPE_NOTE_ON, 4'd15, 8'h22, 8'h30));
      wait_until_drained(SETTLE_CYCLES);
      write_register(REG_POWER_ON, 32'd1);
      send_message(make_word(TYPE_NOTE_OFF, 4'd15, 8'h22, 8'h00));
      // Changing the held channel releases everything as well.
      wait_until_drained(SETTLE_CYCLES);
      write_register(REG_HOLD_CHANNEL, 32'd0);
      send_message(make_word(TYPE_NOTE_ON, 4'd0, 8'h3C, 8'h40));
      wait_until_drained(SETTLE_CYCLES);
      write_register(REG_POWER_ON, 32'd0);
      write_register(REG_POWER_ON, 32'd1);
      send_message(make_word(TYPE_NOTE_OFF, 4'd0, 8'h3C, 8'h00));
   endtask

   task automatic play_chord(input logic [3:0] channel);
      int notes;
      int releases;
      notes = $urandom_range(4, 1);
      releases = $urandom_range(3, 1);
      repeat (notes) begin
         send_message(note_on_word(channel));
         if ($urandom_range(3) == 0) send_message(note_on_word(4'($urandom_range(15))));
      end
      repeat (releases) begin
         send_message(note_off_word(channel));
         if ($urandom_range(4) == 0) send_message(note_off_word(4'($urandom_range(15))));
      end
   endtask

   task automatic play_random_step;
      int pick;
      pick = $urandom_range(99);
      if (pick < 55)
         play_chord(hold_channel_setting);
      else if (pick < 65)
         play_chord(4'($urandom_range(15)));
      else if (pick < 88)
         send_message(req_word_type'({random_byte(), random_byte(), random_byte()}));
      else if (pick < 94)
         send_message(make_word(TYPE_CONTROL, 4'($urandom_range(15)),
                                {1'($urandom_range(1)), CC_ALL_NOTES_OFF}, random_byte()));
      else
         send_message(note_off_word(4'($urandom_range(15))));
   endtask

   task automatic test_random_traffic;
      int phase_goal;
      bit paused;
      paused = 1'b0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_until_drained(SETTLE_CYCLES);
         case (phase)
            0: begin
               write_register(REG_POWER_ON, 32'd1);
               write_register(REG_HOLD_CHANNEL, 32'd0);
            end
            1: begin
               write_register(REG_POWER_ON, 32'd1);
               write_register(REG_HOLD_CHANNEL, 32'd15);
            end
            3: begin
               write_register(REG_POWER_ON, 32'd0);
               write_register(REG_HOLD_CHANNEL, 32'($urandom_range(15)));
            end
            default: begin
               write_register(REG_POWER_ON, 32'($urandom_range(3) != 0));
               write_register(REG_HOLD_CHANNEL, 32'($urandom_range(15)));
            end
         endcase
         gaps_on = (phase != 2);
         stall_on <= (phase != 2);
         phase_goal = messages_sent + RANDOM_MESSAGES / RANDOM_PHASES;
         while (messages_sent < phase_goal) begin
            play_random_step();
            if (phase == 5 && !paused && messages_sent + 20 >= phase_goal) begin
               wait_until_drained(0);
               paused = 1'b1;
            end
         end
      end
      gaps_on = 1'b1;
      stall_on <= 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_messages();
      test_register_changes();
      test_random_traffic();
      wait_until_drained(SETTLE_CYCLES);
      $display("Sent %0d MIDI messages under %0d register writes; checked %0d words,",
               messages_sent, settings_written, words_checked);
      $display("%0d of them release masks, with %0d mismatches.", masks_checked,
               mismatch_count);
      if (mismatch_count == 0)
         $display("midi_chord_hold_unit: match");
      else
         $display("midi_chord_hold_unit: mismatch");
      $finish;
   end

endmodule
